[rtl/rrc_pkg.sv]
package rrc_pkg;

   // widths fixed by the frame format
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int INDEX_W    = 3;
   localparam int STATUS_W   = 3;
   localparam int SLAVE_W    = 8;
   localparam int COUNT_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam int RRC_MAX_REGS = 8;

   // frame layout
   localparam int HDR_LEN   = 5;
   localparam int WRITE_LEN = 8;

   localparam logic [BYTE_W-1:0] FUNC_READ  = 8'h03;
   localparam logic [BYTE_W-1:0] FUNC_WRITE = 8'h06;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [SLAVE_W-1:0] SLAVE_RESET = 8'd1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CRC   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SLAVE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FUNC  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_COUNT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REG   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_VALUE = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              first;
      logic              expect_write;
      logic [WORD_W-1:0] expected_register;
      logic [WORD_W-1:0] expected_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word;
      logic [INDEX_W-1:0]  word_index;
      logic                has_word;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   // control of the crc unit
   typedef struct packed {
      logic restart;
      logic load;
      logic shift;
   } crc_ctl_type;

endpackage

[rtl/register_response_checker_core.sv]
// Response frame checker. Each req_ beat carries one received byte; first=1
// opens a frame and samples whether a read reply or a write echo is expected.
// The crc is folded in by a bit-serial unit: an in-frame byte is accepted,
// then takes eight crc steps in S_CRC with req_ready low; bytes after the
// frame end are accepted and dropped without crc work. At the frame end the
// S_CHECK state settles the status, then either one status beat is sent, or
// the stored words go out through S_READ and S_SEND in turn, set by the
// registered read of the word store. Result beats also wait on rsp_ready; the
// output register lets the next byte be taken while a result is still held.
module register_response_checker_core import rrc_pkg::*; #(
   parameter int MAX_REGS = RRC_MAX_REGS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W   = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam int CNT_W   = $clog2(MAX_REGS + 1);
   localparam int MAX_LEN = (HDR_LEN + 2 * MAX_REGS > WRITE_LEN) ?
                            HDR_LEN + 2 * MAX_REGS : WRITE_LEN;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CRC,
      S_CHECK,
      S_READ,
      S_SEND
   } state_type;

   // configuration
   logic [SLAVE_W-1:0] slave_ff;
   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= SLAVE_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLAVE: slave_ff <= csr_wdata[SLAVE_W-1:0];
            CSR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] cnt;

   always_comb begin
      if (count_ff == '0) begin
         cnt = CNT_W'(1);
      end else if (32'(count_ff) > MAX_REGS) begin
         cnt = CNT_W'(MAX_REGS);
      end else begin
         cnt = CNT_W'(count_ff);
      end
   end

   // frame state
   state_type           state_ff,    state_in;
   logic [LEN_W-1:0]    pos_ff,      pos_in;
   logic                idle_ff,     idle_in;
   logic                end_ff,      end_in;
   logic                wk_ff,       wk_in;
   logic [WORD_W-1:0]   want_reg_ff, want_reg_in;
   logic [WORD_W-1:0]   want_val_ff, want_val_in;
   logic [STATUS_W-1:0] err_ff,      err_in;
   logic [BYTE_W-1:0]   hb_ff,       hb_in;
   logic [2:0]          bit_ff,      bit_in;
   logic [IDX_W-1:0]    idx_ff,      idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   // datapath helpers
   crc_ctl_type         crc_ctl;
   logic [WORD_W-1:0]   crc;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic [WORD_W-1:0]   mem_rdata;

   logic                accept;
   logic                out_free;
   logic                e_wk;
   logic [WORD_W-1:0]   e_reg;
   logic [WORD_W-1:0]   e_val;
   logic [LEN_W-1:0]    e_pos;
   logic                e_idle;
   logic [STATUS_W-1:0] e_err;
   logic [BYTE_W-1:0]   e_hb;
   logic [LEN_W-1:0]    len;
   logic [LEN_W-1:0]    slot;
   logic [STATUS_W-1:0] code;
   logic [STATUS_W-1:0] st;
   logic [BYTE_W-1:0]   b;
   logic [BYTE_W-1:0]   func;
   logic                last_word;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b        = req_data.rx_byte;

   always_comb begin
      // a first beat restarts the frame before the byte is looked at
      e_wk   = req_data.first ? req_data.expect_write      : wk_ff;
      e_reg  = req_data.first ? req_data.expected_register : want_reg_ff;
      e_val  = req_data.first ? req_data.expected_value    : want_val_ff;
      e_pos  = req_data.first ? '0                         : pos_ff;
      e_idle = req_data.first ? 1'b0                       : idle_ff;
      e_err  = req_data.first ? ST_OK                      : err_ff;
      e_hb   = req_data.first ? '0                         : hb_ff;

      len  = e_wk ? LEN_W'(WRITE_LEN) : LEN_W'(HDR_LEN + 2 * 32'(cnt));
      func = e_wk ? FUNC_WRITE : FUNC_READ;
      slot = (e_pos - LEN_W'(4)) >> 1;

      code      = ST_OK;
      hb_in     = e_hb;
      mem_we    = 1'b0;
      mem_waddr = IDX_W'(slot);
      mem_wdata = {e_hb, b};

      if (e_pos == LEN_W'(0)) begin
         if (b != slave_ff) code = ST_SLAVE;
      end else if (e_pos == LEN_W'(1)) begin
         if (b != func) code = ST_FUNC;
      end else if (e_wk) begin
         if (e_pos == LEN_W'(2) && b != e_reg[15:8]) code = ST_REG;
         else if (e_pos == LEN_W'(3) && b != e_reg[7:0]) code = ST_REG;
         else if (e_pos == LEN_W'(4) && b != e_val[15:8]) code = ST_VALUE;
         else if (e_pos == LEN_W'(5) && b != e_val[7:0]) code = ST_VALUE;
      end else if (e_pos == LEN_W'(2)) begin
         if (b != BYTE_W'(2 * 32'(cnt))) code = ST_COUNT;
      end else if ((LEN_W+1)'(e_pos) + (LEN_W+1)'(2) < (LEN_W+1)'(len)) begin
         // data bytes: odd positions carry the high half
         if (e_pos[0]) begin
            hb_in = b;
         end else if (32'(slot) < MAX_REGS) begin
            mem_we = accept && !e_idle;
         end
      end
   end

   always_comb begin
      if (wk_ff) begin
         st = (crc != '0) ? ST_CRC : err_ff;
      end else begin
         st = (err_ff != ST_OK) ? err_ff : ((crc != '0) ? ST_CRC : ST_OK);
      end
      last_word = (32'(idx_ff) + 1 == 32'(cnt));
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idle_in      = idle_ff;
      end_in       = end_ff;
      wk_in        = wk_ff;
      want_reg_in  = want_reg_ff;
      want_val_in  = want_val_ff;
      err_in       = err_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      crc_ctl      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wk_in       = e_wk;
               want_reg_in = e_reg;
               want_val_in = e_val;
               pos_in      = e_pos;
               idle_in     = e_idle;
               err_in      = e_err;
               if (!e_idle) begin
                  crc_ctl.restart = req_data.first;
                  crc_ctl.load    = 1'b1;
                  err_in = (e_err == ST_OK) ? code : e_err;
                  bit_in = '0;
                  if ((LEN_W+1)'(e_pos) + (LEN_W+1)'(1) >= (LEN_W+1)'(len)) begin
                     end_in  = 1'b1;
                     idle_in = 1'b1;
                  end else begin
                     end_in = 1'b0;
                     pos_in = e_pos + LEN_W'(1);
                  end
                  state_in = S_CRC;
               end
            end
         end
         S_CRC: begin
            crc_ctl.shift = 1'b1;
            bit_in        = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               state_in = end_ff ? S_CHECK : S_IDLE;
            end
         end
         S_CHECK: begin
            if (st != ST_OK || wk_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{word: '0, word_index: '0, has_word: 1'b0,
                                   status: st, last: 1'b1};
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // store read issued here, data lands next cycle
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{word: mem_rdata, word_index: INDEX_W'(idx_ff),
                                has_word: 1'b1, status: ST_OK, last: last_word};
               if (last_word) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         idle_ff      <= 1'b0;
         end_ff       <= 1'b0;
         wk_ff        <= 1'b0;
         want_reg_ff  <= '0;
         want_val_ff  <= '0;
         err_ff       <= ST_OK;
         hb_ff        <= '0;
         bit_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idle_ff      <= idle_in;
         end_ff       <= end_in;
         wk_ff        <= wk_in;
         want_reg_ff  <= want_reg_in;
         want_val_ff  <= want_val_in;
         err_ff       <= err_in;
         if (accept) hb_ff <= hb_in;
         bit_ff       <= bit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   rrc_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .data_byte (b),
      .crc       (crc)
   );

   rrc_word_store #(
      .DEPTH (MAX_REGS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/rrc_crc_unit.sv]
module rrc_crc_unit import rrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  crc_ctl_type       ctl,
   input  logic [BYTE_W-1:0] data_byte,
   output logic [WORD_W-1:0] crc
);

   logic [WORD_W-1:0] crc_ff;
   logic [WORD_W-1:0] crc_in;
   logic [WORD_W-1:0] base;

   always_comb begin
      base   = ctl.restart ? CRC_INIT : crc_ff;
      crc_in = crc_ff;
      if (ctl.load) begin
         crc_in = base ^ {{(WORD_W-BYTE_W){1'b0}}, data_byte};
      end else if (ctl.shift) begin
         // one bit of the reflected division per cycle
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

[rtl/rrc_word_store.sv]
module rrc_word_store import rrc_pkg::*; #(
   parameter int DEPTH = RRC_MAX_REGS,
   parameter int IDX_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rrc_checker.sv]
module rrc_checker import rrc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a held result beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a status beat closes the frame and carries no word
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_word |->
         rsp_data.last && rsp_data.word == '0 && rsp_data.word_index == '0)
      else $error("malformed status beat");

   a_word_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_word |-> rsp_data.status == ST_OK)
      else $error("word beat with failing status");

endmodule

bind register_response_checker_core rrc_checker u_rrc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/register_response_checker_core_test.sv]
module register_response_checker_core_test;
   import rrc_pkg::*;

   localparam int IDLE_POS      = 31;
   localparam int LONG_HOLD     = 1000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {
      FAULT_NONE,
      FAULT_SLAVE,
      FAULT_FUNC,
      FAULT_FIELD,
      FAULT_CRC
   } fault_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   register_response_checker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   req_type pending_bytes[$];
   rsp_type expected_results[$];

   int fail_count   = 0;
   bit steady       = 1'b0;
   int hold_request = 0;
   int hold_seen    = 0;
   int send_gap     = 0;
   int recv_gap     = 0;
   int recv_hold    = 0;

   // frame checker state as the block should hold it
   logic [SLAVE_W-1:0]  slave_cfg      = SLAVE_RESET;
   logic [COUNT_W-1:0]  count_cfg      = COUNT_RESET;
   logic [WORD_W-1:0]   crc_run        = CRC_INIT;
   int                  frame_pos      = 0;
   logic                echo_expected  = 1'b0;
   logic [WORD_W-1:0]   reg_wanted     = '0;
   logic [WORD_W-1:0]   value_wanted   = '0;
   logic [STATUS_W-1:0] frame_status   = ST_OK;
   logic [BYTE_W-1:0]   data_high      = '0;
   logic [WORD_W-1:0]   stored_words [RRC_MAX_REGS] = '{default: '0};

   function automatic logic [WORD_W-1:0] crc16_step(logic [WORD_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic int reply_words();
      int c;
      c = count_cfg;
      if (c < 1) c = 1;
      if (c > RRC_MAX_REGS) c = RRC_MAX_REGS;
      return c;
   endfunction

   function automatic void note_status(logic [STATUS_W-1:0] code);
      if (frame_status == ST_OK) frame_status = code;
   endfunction

   function automatic void predict_frame_results(req_type r);
      int      cnt;
      int      len;
      int      p;
      logic [STATUS_W-1:0] st;
      rsp_type o;
      cnt = reply_words();
      if (r.first) begin
         crc_run       = CRC_INIT;
         frame_pos     = 0;
         echo_expected = r.expect_write;
         reg_wanted    = r.expected_register;
         value_wanted  = r.expected_value;
         frame_status  = ST_OK;
         data_high     = '0;
      end
      if (frame_pos >= IDLE_POS) return;
      len = echo_expected ? WRITE_LEN : HDR_LEN + 2 * cnt;
      p = frame_pos;
      crc_run = crc16_step(crc_run, r.rx_byte);
      if (p == 0) begin
         if (r.rx_byte != slave_cfg) note_status(ST_SLAVE);
      end else if (p == 1) begin
         if (r.rx_byte != (echo_expected ? FUNC_WRITE : FUNC_READ)) note_status(ST_FUNC);
      end else if (echo_expected) begin
         case (p)
            2: if (r.rx_byte != reg_wanted[15:8]) note_status(ST_REG);
            3: if (r.rx_byte != reg_wanted[7:0]) note_status(ST_REG);
            4: if (r.rx_byte != value_wanted[15:8]) note_status(ST_VALUE);
            5: if (r.rx_byte != value_wanted[7:0]) note_status(ST_VALUE);
            default: ;
         endcase
      end else if (p == 2) begin
         if (r.rx_byte != 8'(2 * cnt)) note_status(ST_COUNT);
      end else if (p + 2 < len) begin
         // odd positions carry the high byte of a data word
         if (p % 2 == 1) data_high = r.rx_byte;
         else stored_words[(p - 4) / 2] = {data_high, r.rx_byte};
      end
      if (p + 1 >= len) begin
         if (echo_expected) st = (crc_run != 0) ? ST_CRC : frame_status;
         else st = (frame_status != ST_OK) ? frame_status : ((crc_run != 0) ? ST_CRC : ST_OK);
         if (st != ST_OK || echo_expected) begin
            o.word       = '0;
            o.word_index = '0;
            o.has_word   = 1'b0;
            o.status     = st;
            o.last       = 1'b1;
            expected_results.insert(expected_results.size(), o);
         end else begin
            for (int i = 0; i < cnt; i++) begin
               o.word       = stored_words[i];
               o.word_index = INDEX_W'(i);
               o.has_word   = 1'b1;
               o.status     = ST_OK;
               o.last       = (i + 1 == cnt);
               expected_results.insert(expected_results.size(), o);
            end
         end
         frame_pos = IDLE_POS;
      end else begin
         frame_pos = p + 1;
      end
   endfunction

   // sender: one beat per pending byte, random gap after each accept unless steady
   always @(posedge clock) begin : send_side
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) predict_frame_results(req_data);
         if (req_valid && !req_ready) begin
            // beat still on offer
         end else if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes[0];
            pending_bytes.delete(0);
            req_data  <= nxt;
            req_valid <= 1'b1;
            send_gap  <= steady ? 0 : $urandom_range(0, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: checks each result beat, random stalls unless steady and one long hold-off
   always @(posedge clock) begin : recv_side
      rsp_type want;
      logic    rdy;
      int      gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
         recv_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"unexpected result beat: word %h index %0d has_word %b",
                            " status %0d last %b"},
                           rsp_data.word, rsp_data.word_index, rsp_data.has_word,
                           rsp_data.status, rsp_data.last);
               fail_count++;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_data.word !== want.word || rsp_data.word_index !== want.word_index ||
                   rsp_data.has_word !== want.has_word || rsp_data.status !== want.status ||
                   rsp_data.last !== want.last) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"result mismatch: expected word %h index %0d has_word %b",
                               " status %0d last %b, got word %h index %0d has_word %b",
                               " status %0d last %b"},
                              want.word, want.word_index, want.has_word, want.status,
                              want.last, rsp_data.word, rsp_data.word_index,
                              rsp_data.has_word, rsp_data.status, rsp_data.last);
                  fail_count++;
               end
            end
         end
         if (hold_seen != hold_request) begin
            hold_seen <= hold_request;
            recv_hold <= LONG_HOLD;
            rdy = 1'b0;
         end else if (recv_hold != 0) begin
            recv_hold <= recv_hold - 1;
            rdy = 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            gap = steady ? 0 : $urandom_range(0, 7);
            recv_gap <= gap;
            rdy = (gap == 0);
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rdy = (recv_gap == 1);
         end else begin
            rdy = 1'b1;
         end
         rsp_ready <= rdy;
      end
   end

   function automatic int queue_noise(int n, bit allow_first);
      req_type r;
      for (int k = 0; k < n; k++) begin
         r.rx_byte           = 8'($urandom);
         r.first             = allow_first ? 1'($urandom) : 1'b0;
         r.expect_write      = 1'($urandom);
         r.expected_register = 16'($urandom);
         r.expected_value    = 16'($urandom);
         pending_bytes.insert(pending_bytes.size(), r);
      end
      return n;
   endfunction

   // builds one response frame; header faults go in before the crc is appended
   function automatic int queue_frame(logic as_write, fault_type fault, bit headless, int cut,
                                      logic [WORD_W-1:0] reg_w, logic [WORD_W-1:0] val_w);
      logic [BYTE_W-1:0] fb[$];
      logic [WORD_W-1:0] crc;
      req_type           r;
      int                n;
      int                k;
      fb.insert(fb.size(), slave_cfg);
      fb.insert(fb.size(), as_write ? FUNC_WRITE : FUNC_READ);
      if (as_write) begin
         fb.insert(fb.size(), reg_w[15:8]);
         fb.insert(fb.size(), reg_w[7:0]);
         fb.insert(fb.size(), val_w[15:8]);
         fb.insert(fb.size(), val_w[7:0]);
      end else begin
         fb.insert(fb.size(), 8'(2 * reply_words()));
         for (int i = 0; i < 2 * reply_words(); i++) fb.insert(fb.size(), 8'($urandom));
      end
      case (fault)
         FAULT_SLAVE: fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
         FAULT_FUNC:  fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
         FAULT_FIELD: begin
            k = as_write ? $urandom_range(2, 5) : 2;
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
         end
         default: ;
      endcase
      crc = CRC_INIT;
      foreach (fb[i]) crc = crc16_step(crc, fb[i]);
      fb.insert(fb.size(), crc[7:0]);
      fb.insert(fb.size(), crc[15:8]);
      if (fault == FAULT_CRC) begin
         k = $urandom_range(0, fb.size() - 1);
         fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
      end
      n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
      for (int i = 0; i < n; i++) begin
         r.rx_byte           = fb[i];
         r.first             = (i == 0) && !headless;
         r.expect_write      = (i == 0) ? as_write : 1'($urandom);
         r.expected_register = (i == 0) ? reg_w : 16'($urandom);
         r.expected_value    = (i == 0) ? val_w : 16'($urandom);
         pending_bytes.insert(pending_bytes.size(), r);
      end
      return n;
   endfunction

   function automatic int queue_random_frame();
      int        sel;
      logic      w;
      int        len;
      fault_type f;
      sel = $urandom_range(0, 19);
      w   = 1'($urandom);
      if (sel < 9) begin
         return queue_frame(1'b0, FAULT_NONE, 1'b0, 0, 16'($urandom), 16'($urandom));
      end else if (sel < 13) begin
         return queue_frame(1'b1, FAULT_NONE, 1'b0, 0, 16'($urandom), 16'($urandom));
      end else if (sel < 16) begin
         f = fault_type'($urandom_range(1, 4));
         return queue_frame(w, f, 1'b0, 0, 16'($urandom), 16'($urandom));
      end else if (sel < 18) begin
         // cut short, the next first byte restarts the parser
         len = w ? WRITE_LEN : HDR_LEN + 2 * reply_words();
         return queue_frame(w, FAULT_NONE, 1'b0, $urandom_range(1, len - 1),
                            16'($urandom), 16'($urandom));
      end else if (sel == 18) begin
         return queue_noise($urandom_range(1, 4), 1'b1);
      end else begin
         len = queue_frame(1'b1, FAULT_NONE, 1'b0, 0, 16'($urandom), 16'($urandom));
         void'(queue_noise($urandom_range(1, 3), 1'b0));
         return len;
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SLAVE) slave_cfg = data;
      else count_cfg = data[COUNT_W-1:0];
   endtask

   task automatic drain_results();
      int n;
      n = 0;
      while ((pending_bytes.size() != 0 || req_valid || expected_results.size() != 0) &&
             n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      // a trailing byte with no result may still be in the crc unit
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [SLAVE_W-1:0] slave, input logic [COUNT_W-1:0] count,
                            input int budget, input bit quiet, input bit long_stall);
      int sent;
      drain_results();
      write_csr(CSR_SLAVE, slave);
      write_csr(CSR_COUNT, {4'($urandom), count});
      steady = quiet;
      if (long_stall) hold_request++;
      sent = queue_frame(1'b0, FAULT_NONE, 1'b0, 0, 16'($urandom), 16'($urandom));
      while (sent < budget) sent += queue_random_frame();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_SLAVE, 8'd247);
      write_csr(CSR_COUNT, 8'h00);
      // no first byte since reset: taken as a read reply
      void'(queue_frame(1'b0, FAULT_NONE, 1'b1, 0, 16'h0000, 16'h0000));
      void'(queue_noise(1, 1'b0));
      void'(queue_frame(1'b1, FAULT_NONE, 1'b0, 0, 16'hFFFF, 16'h0000));
      void'(queue_frame(1'b0, FAULT_FIELD, 1'b0, 0, 16'h0000, 16'hFFFF));

      run_phase(8'd1,   4'd8,  30, 1'b0, 1'b1);
      run_phase(8'd0,   4'd15, 25, 1'b1, 1'b0);
      run_phase(8'd255, 4'd1,  20, 1'b0, 1'b0);
      run_phase(8'd247, 4'd8,  25, 1'b0, 1'b0);
      run_phase(8'($urandom), 4'($urandom), 20, 1'b0, 1'b0);
      run_phase(8'($urandom), 4'($urandom), 20, 1'b0, 1'b0);

      drain_results();
      if (expected_results.size() != 0) begin
         if (fail_count < REPORT_LIMIT)
            $display("results never delivered: %0d", expected_results.size());
         fail_count += expected_results.size();
      end
      if (fail_count == 0) begin
         $display("register_response_checker_core test passed");
      end else begin
         $display("register_response_checker_core test failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("register_response_checker_core test failed");
      $finish;
   end

endmodule
